@@ rtl/ris_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_pkg - shared types and constants of the image resampling scaler
// Field widths, register indexes, transaction structs and the control group
// that travels between the pipeline stages.
// ----------------------------------------------------------------------------
package ris_pkg;

  // fixed field widths
  localparam int POS_W      = 10;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SRC_SIZE_W = 9;
  localparam int OUT_SIZE_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // parameter defaults
  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;
  localparam int DEF_FRAC_BITS      = 8;

  // register reset values
  localparam logic [SRC_SIZE_W-1:0] RST_SRC_WIDTH  = 9'd256;
  localparam logic [SRC_SIZE_W-1:0] RST_SRC_HEIGHT = 9'd256;
  localparam logic [OUT_SIZE_W-1:0] RST_OUT_SIZE   = 10'd256;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } interp_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 2'd0,
    REG_SRC_HEIGHT  = 2'd1,
    REG_OUT_SIZE    = 2'd2,
    REG_INTERP_MODE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_item_t;

  // effective configuration (sizes already forced into range)
  typedef struct packed {
    logic [SRC_SIZE_W-1:0] src_width;
    logic [SRC_SIZE_W-1:0] src_height;
    logic [OUT_SIZE_W-1:0] out_size;
    interp_mode_t          mode;
  } cfg_t;

  // per-stage control group
  typedef struct packed {
    logic valid;
    logic sample;
    logic write;
  } ctl_t;

  // parities of the neighbour coordinates, select the banks
  typedef struct packed {
    logic x0;
    logic x1;
    logic y0;
    logic y1;
  } nbr_par_t;

endpackage

@@ rtl/ris_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_divider - pipelined restoring divider
// One quotient bit per register stage, MSB first, in NUM_W register stages.
// ----------------------------------------------------------------------------
module ris_divider #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [NUM_W-1];
  logic [NUM_W-1:0] num_r [NUM_W-1];
  logic [NUM_W-1:0] quo_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // shift in the next numerator bit and try the subtraction
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[NUM_W-2:0], take};
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
          num_r[k] <= {num_in[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[NUM_W-1];

endmodule

@@ rtl/ris_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_map - output coordinate to fixed-point source position
// Multiplies the coordinate by the source size, then divides by the output
// size in two divider lanes while the transaction travels alongside.
// ----------------------------------------------------------------------------
module ris_map #(
  parameter int FRAC_BITS = ris_pkg::DEF_FRAC_BITS,
  parameter int NUM_W     = ris_pkg::POS_W + ris_pkg::SRC_SIZE_W + ris_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ris_pkg::in_item_t  in_item,
  input  ris_pkg::cfg_t      cfg,
  output logic               out_valid,
  output ris_pkg::in_item_t  out_item,
  output logic [NUM_W-1:0]   ux,
  output logic [NUM_W-1:0]   uy
);

  localparam int PROD_W = ris_pkg::POS_W + ris_pkg::SRC_SIZE_W;

  logic              v0_r;
  ris_pkg::in_item_t item0_r;
  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic              v_sb_r    [NUM_W];
  ris_pkg::in_item_t item_sb_r [NUM_W];

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0_r  <= in_item;
      prod_x_r <= PROD_W'(in_item.pos_x) * PROD_W'(cfg.src_width);
      prod_y_r <= PROD_W'(in_item.pos_y) * PROD_W'(cfg.src_height);
    end
  end

  // divider lanes
  ris_divider #(
    .NUM_W (NUM_W),
    .DEN_W (ris_pkg::OUT_SIZE_W)
  ) u_div_x (
    .clk (clk),
    .en  (en),
    .num (NUM_W'({prod_x_r, {FRAC_BITS{1'b0}}})),
    .den (cfg.out_size),
    .quo (ux)
  );

  ris_divider #(
    .NUM_W (NUM_W),
    .DEN_W (ris_pkg::OUT_SIZE_W)
  ) u_div_y (
    .clk (clk),
    .en  (en),
    .num (NUM_W'({prod_y_r, {FRAC_BITS{1'b0}}})),
    .den (cfg.out_size),
    .quo (uy)
  );

  // transaction sideband, aligned with the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_W; k++) begin
        v_sb_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_sb_r[0] <= v0_r;
      for (int k = 1; k < NUM_W; k++) begin
        v_sb_r[k] <= v_sb_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_sb_r[0] <= item0_r;
      for (int k = 1; k < NUM_W; k++) begin
        item_sb_r[k] <= item_sb_r[k-1];
      end
    end
  end

  assign out_valid = v_sb_r[NUM_W-1];
  assign out_item  = item_sb_r[NUM_W-1];

endmodule

@@ rtl/ris_addr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_addr - neighbour selection
// Rounds or floors the source position, clamps to the image and produces
// the neighbour coordinates and fractions; write transactions pass their
// store coordinate and range check.
// ----------------------------------------------------------------------------
module ris_addr #(
  parameter int MAX_SRC_WIDTH  = ris_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = ris_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = ris_pkg::DEF_FRAC_BITS,
  parameter int NUM_W          = ris_pkg::POS_W + ris_pkg::SRC_SIZE_W + ris_pkg::DEF_FRAC_BITS,
  parameter int XW             = $clog2(ris_pkg::DEF_MAX_SRC_WIDTH),
  parameter int YW             = $clog2(ris_pkg::DEF_MAX_SRC_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  ris_pkg::in_item_t         in_item,
  input  logic [NUM_W-1:0]          ux,
  input  logic [NUM_W-1:0]          uy,
  input  ris_pkg::cfg_t             cfg,
  output ris_pkg::ctl_t             ctl,
  output logic [XW-1:0]             x0,
  output logic [XW-1:0]             x1,
  output logic [YW-1:0]             y0,
  output logic [YW-1:0]             y1,
  output logic [FRAC_BITS-1:0]      fx,
  output logic [FRAC_BITS-1:0]      fy,
  output logic [ris_pkg::PIX_W-1:0] pix
);

  localparam int IX_W = NUM_W - FRAC_BITS + 1;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  logic [XW-1:0]        last_x;
  logic [YW-1:0]        last_y;
  logic [IX_W-1:0]      fl_x, fl_y, rn_x, rn_y, fl1_x, fl1_y, ix, iy;
  logic                 bilin, is_write, in_range;
  ris_pkg::ctl_t        ctl_nxt, ctl_r;
  logic [XW-1:0]        x0_nxt, x1_nxt, x0_r, x1_r, cx0, cx1;
  logic [YW-1:0]        y0_nxt, y1_nxt, y0_r, y1_r, cy0, cy1;
  logic [FRAC_BITS-1:0] fx_nxt, fy_nxt, fx_r, fy_r;
  logic [ris_pkg::PIX_W-1:0] pix_r;

  assign last_x = XW'(cfg.src_width - 1'b1);
  assign last_y = YW'(cfg.src_height - 1'b1);
  assign bilin  = (cfg.mode == ris_pkg::MODE_BILINEAR);

  // integer parts: floor, floor plus one, and rounded half up
  assign fl_x  = IX_W'(ux >> FRAC_BITS);
  assign fl_y  = IX_W'(uy >> FRAC_BITS);
  assign fl1_x = fl_x + 1'b1;
  assign fl1_y = fl_y + 1'b1;
  assign rn_x  = IX_W'(({1'b0, ux} + (NUM_W + 1)'(HALF)) >> FRAC_BITS);
  assign rn_y  = IX_W'(({1'b0, uy} + (NUM_W + 1)'(HALF)) >> FRAC_BITS);
  assign ix    = bilin ? fl_x : rn_x;
  assign iy    = bilin ? fl_y : rn_y;

  // clamp to the last column and row
  assign cx0 = (ix > IX_W'(last_x)) ? last_x : XW'(ix);
  assign cy0 = (iy > IX_W'(last_y)) ? last_y : YW'(iy);
  assign cx1 = (fl1_x > IX_W'(last_x)) ? last_x : XW'(fl1_x);
  assign cy1 = (fl1_y > IX_W'(last_y)) ? last_y : YW'(fl1_y);

  assign is_write = (in_item.opcode == ris_pkg::OP_WRITE);
  assign in_range = (32'(in_item.pos_x) < MAX_SRC_WIDTH) &&
                    (32'(in_item.pos_y) < MAX_SRC_HEIGHT);

  // nearest mode reuses the blend with zero fractions on one neighbour
  always_comb begin
    ctl_nxt.valid  = in_valid;
    ctl_nxt.sample = !is_write;
    ctl_nxt.write  = is_write && in_range;
    if (is_write) begin
      x0_nxt = XW'(in_item.pos_x);
      y0_nxt = YW'(in_item.pos_y);
      x1_nxt = x0_nxt;
      y1_nxt = y0_nxt;
      fx_nxt = '0;
      fy_nxt = '0;
    end else if (bilin) begin
      x0_nxt = cx0;
      y0_nxt = cy0;
      x1_nxt = cx1;
      y1_nxt = cy1;
      fx_nxt = ux[FRAC_BITS-1:0];
      fy_nxt = uy[FRAC_BITS-1:0];
    end else begin
      x0_nxt = cx0;
      y0_nxt = cy0;
      x1_nxt = cx0;
      y1_nxt = cy0;
      fx_nxt = '0;
      fy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x0_nxt;
      x1_r  <= x1_nxt;
      y0_r  <= y0_nxt;
      y1_r  <= y1_nxt;
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      pix_r <= {in_item.red_in, in_item.green_in, in_item.blue_in};
    end
  end

  assign ctl = ctl_r;
  assign x0  = x0_r;
  assign x1  = x1_r;
  assign y0  = y0_r;
  assign y1  = y1_r;
  assign fx  = fx_r;
  assign fy  = fy_r;
  assign pix = pix_r;

endmodule

@@ rtl/ris_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_store - banked frame store
// Four banks split by column and row parity, so distinct bilinear neighbours
// always fall in distinct banks, and all four banks are read in the same cycle.
// ----------------------------------------------------------------------------
module ris_store #(
  parameter int MAX_SRC_WIDTH  = ris_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = ris_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = ris_pkg::DEF_FRAC_BITS,
  parameter int XW             = $clog2(ris_pkg::DEF_MAX_SRC_WIDTH),
  parameter int YW             = $clog2(ris_pkg::DEF_MAX_SRC_HEIGHT)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  ris_pkg::ctl_t                    ctl_in,
  input  logic [XW-1:0]                    x0,
  input  logic [XW-1:0]                    x1,
  input  logic [YW-1:0]                    y0,
  input  logic [YW-1:0]                    y1,
  input  logic [FRAC_BITS-1:0]             fx_in,
  input  logic [FRAC_BITS-1:0]             fy_in,
  input  logic [ris_pkg::PIX_W-1:0]        pix,
  output ris_pkg::ctl_t                    ctl_out,
  output ris_pkg::nbr_par_t                par_out,
  output logic [FRAC_BITS-1:0]             fx_out,
  output logic [FRAC_BITS-1:0]             fy_out,
  output logic [3:0][ris_pkg::PIX_W-1:0]   rd_pix
);

  localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  ris_pkg::ctl_t             ctl_r;
  ris_pkg::nbr_par_t         par_r;
  logic [FRAC_BITS-1:0]      fx_r, fy_r;
  logic [ris_pkg::PIX_W-1:0] rd_r [4];

  // one bank per column and row parity
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);

    logic [XW-1:0]             col;
    logic [YW-1:0]             row;
    logic [AW-1:0]             addr;
    logic                      wr;
    logic [ris_pkg::PIX_W-1:0] mem [BANK_DEPTH];

    assign col  = (x0[0] == BX) ? x0 : x1;
    assign row  = (y0[0] == BY) ? y0 : y1;
    assign addr = AW'((int'(row) >> 1) * HALF_W + (int'(col) >> 1));
    assign wr   = en && ctl_in.valid && ctl_in.write && (x0[0] == BX) && (y0[0] == BY);

    always_ff @(posedge clk) begin
      if (wr) begin
        mem[addr] <= pix;
      end
      if (en) begin
        rd_r[b] <= mem[addr];
      end
    end

    assign rd_pix[b] = rd_r[b];
  end

  // sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_r <= '{x0: x0[0], x1: x1[0], y0: y0[0], y1: y1[0]};
      fx_r  <= fx_in;
      fy_r  <= fy_in;
    end
  end

  assign ctl_out = ctl_r;
  assign par_out = par_r;
  assign fx_out  = fx_r;
  assign fy_out  = fy_r;

endmodule

@@ rtl/ris_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_blend - bilinear weighting
// Weights, per-channel products and the final sum in three register
// stages; the last stage is the output register.
// ----------------------------------------------------------------------------
module ris_blend #(
  parameter int FRAC_BITS = ris_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ris_pkg::ctl_t                  ctl,
  input  ris_pkg::nbr_par_t              par,
  input  logic [FRAC_BITS-1:0]           fx,
  input  logic [FRAC_BITS-1:0]           fy,
  input  logic [3:0][ris_pkg::PIX_W-1:0] rd_pix,
  output logic                           out_valid,
  output ris_pkg::out_item_t             out_item
);

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int W_W   = 2 * FRAC_BITS + 1;
  localparam int PR_W  = W_W + ris_pkg::CH_W;
  localparam int SUM_W = PR_W + 2;
  localparam int CH_W  = ris_pkg::CH_W;

  logic [ONE_W-1:0]          gx, gy;
  logic [W_W-1:0]            wt_nxt [4];
  logic [ris_pkg::PIX_W-1:0] px_nxt [4];
  logic                      v1_r, v2_r, v3_r;
  logic [W_W-1:0]            wt_r   [4];
  logic [ris_pkg::PIX_W-1:0] px_r   [4];
  logic [PR_W-1:0]           prod_r [3][4];
  logic [SUM_W-1:0]          sum_nxt [3];
  ris_pkg::out_item_t        out_r;

  assign gx = ONE_W'(1 << FRAC_BITS) - {1'b0, fx};
  assign gy = ONE_W'(1 << FRAC_BITS) - {1'b0, fy};

  // neighbour order: upper left, upper right, lower left, lower right
  always_comb begin
    px_nxt[0] = rd_pix[{par.y0, par.x0}];
    px_nxt[1] = rd_pix[{par.y0, par.x1}];
    px_nxt[2] = rd_pix[{par.y1, par.x0}];
    px_nxt[3] = rd_pix[{par.y1, par.x1}];
    wt_nxt[0] = W_W'(gx) * W_W'(gy);
    wt_nxt[1] = W_W'(fx) * W_W'(gy);
    wt_nxt[2] = W_W'(gx) * W_W'(fy);
    wt_nxt[3] = W_W'(fx) * W_W'(fy);
  end

  // valid bits, write transactions end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= ctl.valid && ctl.sample;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // weight stage and product stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        wt_r[k] <= wt_nxt[k];
        px_r[k] <= px_nxt[k];
      end
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[c][k] <= PR_W'(wt_r[k]) *
                          PR_W'(px_r[k][ris_pkg::PIX_W-1-CH_W*c -: CH_W]);
        end
      end
    end
  end

  // sum stage
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) +
                   SUM_W'(prod_r[c][2]) + SUM_W'(prod_r[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.red_out   <= sum_nxt[0][2*FRAC_BITS +: CH_W];
      out_r.green_out <= sum_nxt[1][2*FRAC_BITS +: CH_W];
      out_r.blue_out  <= sum_nxt[2][2*FRAC_BITS +: CH_W];
    end
  end

  assign out_valid = v3_r;
  assign out_item  = out_r;

endmodule

@@ rtl/rgb_image_resample_sampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_image_resample_sampler_core - image resampling scaler
// Frame store for RGB source pixels and a pipelined sampler with nearest
// and bilinear modes.
// ----------------------------------------------------------------------------
// usage
//   in_*  : transactions with opcode write (store one source pixel) or sample
//           (give an output column and row); one accepted per unstalled clock
//   out_* : one RGB result per sample transaction, in order; writes give none
//   cfg_* : register writes; the user must make them only while the pipeline is empty, the block does not enforce it
// depth
//   the product stage, then the bit-per-stage divider of POS_W + 9 + FRAC_BITS
//   stages, followed by address, store read and three blend stages
// throughput
//   one transaction per cycle unless stalled; the four neighbours come from
//   four parity banks of the frame store, all read in the same cycle
// reset
//   clears all valid bits and loads the size and mode registers; the frame
//   store keeps whatever it holds and must be written before it is read
// stall
//   out_stall with a result waiting freezes the whole pipeline and raises
//   in_stall in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module rgb_image_resample_sampler_core #(
  parameter int MAX_SRC_WIDTH  = ris_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = ris_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = ris_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ris_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ris_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [ris_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ris_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NUM_W = ris_pkg::POS_W + ris_pkg::SRC_SIZE_W + FRAC_BITS;
  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int SW    = ris_pkg::SRC_SIZE_W;
  localparam int OW    = ris_pkg::OUT_SIZE_W;

  logic [SW-1:0]         src_width_r, src_height_r;
  logic [OW-1:0]         out_size_r;
  ris_pkg::interp_mode_t mode_r;
  ris_pkg::cfg_t         cfg;
  logic                  en;

  logic                      map_valid;
  ris_pkg::in_item_t         map_item;
  logic [NUM_W-1:0]          ux, uy;
  ris_pkg::ctl_t             addr_ctl, store_ctl;
  logic [XW-1:0]             x0, x1;
  logic [YW-1:0]             y0, y1;
  logic [FRAC_BITS-1:0]      fx, fy, st_fx, st_fy;
  logic [ris_pkg::PIX_W-1:0] wr_pix;
  ris_pkg::nbr_par_t         st_par;
  logic [3:0][ris_pkg::PIX_W-1:0] rd_pix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= ris_pkg::RST_SRC_WIDTH;
      src_height_r <= ris_pkg::RST_SRC_HEIGHT;
      out_size_r   <= ris_pkg::RST_OUT_SIZE;
      mode_r       <= ris_pkg::MODE_NEAREST;
    end else if (cfg_we) begin
      unique case (ris_pkg::cfg_reg_t'(cfg_index))
        ris_pkg::REG_SRC_WIDTH:   src_width_r  <= cfg_data[SW-1:0];
        ris_pkg::REG_SRC_HEIGHT:  src_height_r <= cfg_data[SW-1:0];
        ris_pkg::REG_OUT_SIZE:    out_size_r   <= cfg_data[OW-1:0];
        ris_pkg::REG_INTERP_MODE: mode_r       <= ris_pkg::interp_mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, source sizes saturate at the store
  always_comb begin
    if (src_width_r == '0) begin
      cfg.src_width = SW'(1);
    end else if (32'(src_width_r) > MAX_SRC_WIDTH) begin
      cfg.src_width = SW'(MAX_SRC_WIDTH);
    end else begin
      cfg.src_width = src_width_r;
    end
    if (src_height_r == '0) begin
      cfg.src_height = SW'(1);
    end else if (32'(src_height_r) > MAX_SRC_HEIGHT) begin
      cfg.src_height = SW'(MAX_SRC_HEIGHT);
    end else begin
      cfg.src_height = src_height_r;
    end
    cfg.out_size = (out_size_r == '0) ? OW'(1) : out_size_r;
    cfg.mode     = mode_r;
  end

  // whole pipeline advances unless a waiting result is stalled
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  ris_map #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .cfg       (cfg),
    .out_valid (map_valid),
    .out_item  (map_item),
    .ux        (ux),
    .uy        (uy)
  );

  ris_addr #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS),
    .NUM_W          (NUM_W),
    .XW             (XW),
    .YW             (YW)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (map_valid),
    .in_item  (map_item),
    .ux       (ux),
    .uy       (uy),
    .cfg      (cfg),
    .ctl      (addr_ctl),
    .x0       (x0),
    .x1       (x1),
    .y0       (y0),
    .y1       (y1),
    .fx       (fx),
    .fy       (fy),
    .pix      (wr_pix)
  );

  ris_store #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS),
    .XW             (XW),
    .YW             (YW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (addr_ctl),
    .x0      (x0),
    .x1      (x1),
    .y0      (y0),
    .y1      (y1),
    .fx_in   (fx),
    .fy_in   (fy),
    .pix     (wr_pix),
    .ctl_out (store_ctl),
    .par_out (st_par),
    .fx_out  (st_fx),
    .fy_out  (st_fy),
    .rd_pix  (rd_pix)
  );

  ris_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (store_ctl),
    .par       (st_par),
    .fx        (st_fx),
    .fy        (st_fy),
    .rd_pix    (rd_pix),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

`ifndef NO_ASSERTIONS
  // input side only held back by a result waiting on a stalled receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the image resampling scaler
// Drives write and sample transactions through the valid/stall channels,
// predicts every sampled pixel from a private copy of the frame store and
// the size and mode registers, and compares results in order.
// ----------------------------------------------------------------------------
module tb_top;

  // scoreboard: frame store copy, register copy and pending pixels
  class pixel_scoreboard;
    logic [ris_pkg::PIX_W-1:0] pixels [65536];
    bit                        written [65536];
    int unsigned               src_w = 256, src_h = 256, out_n = 256;
    ris_pkg::interp_mode_t     mode  = ris_pkg::MODE_NEAREST;
    ris_pkg::out_item_t        pending [$];
    int                        errors = 0;

    function void set_reg(ris_pkg::cfg_reg_t idx, int unsigned val);
      case (idx)
        ris_pkg::REG_SRC_WIDTH:   src_w = val & 'h1FF;
        ris_pkg::REG_SRC_HEIGHT:  src_h = val & 'h1FF;
        ris_pkg::REG_OUT_SIZE:    out_n = val & 'h3FF;
        ris_pkg::REG_INTERP_MODE: mode  = ris_pkg::interp_mode_t'(val & 1);
        default: ;
      endcase
    endfunction

    // neighbour coordinates and fractions of an output position
    function void neighbours(int unsigned px, int unsigned py,
                             output int unsigned x0, x1, y0, y1,
                             output longint unsigned fx, fy);
      int unsigned w, h, n;
      longint unsigned ux, uy;
      w  = (src_w == 0) ? 1 : (src_w > 256 ? 256 : src_w);
      h  = (src_h == 0) ? 1 : (src_h > 256 ? 256 : src_h);
      n  = (out_n == 0) ? 1 : out_n;
      ux = ((longint'(px) * w) << 8) / n;
      uy = ((longint'(py) * h) << 8) / n;
      if (mode == ris_pkg::MODE_NEAREST) begin
        ux = (ux + 128) >> 8;
        uy = (uy + 128) >> 8;
        x0 = 32'((ux > w - 1) ? w - 1 : ux);
        y0 = 32'((uy > h - 1) ? h - 1 : uy);
        x1 = x0;
        y1 = y0;
        fx = 0;
        fy = 0;
      end else begin
        x0 = 32'(((ux >> 8) > w - 1) ? w - 1 : (ux >> 8));
        y0 = 32'(((uy >> 8) > h - 1) ? h - 1 : (uy >> 8));
        x1 = (x0 < w - 1) ? x0 + 1 : w - 1;
        y1 = (y0 < h - 1) ? y0 + 1 : h - 1;
        fx = ux & 255;
        fy = uy & 255;
      end
    endfunction

    function void note_input(ris_pkg::in_item_t it);
      int unsigned x0, x1, y0, y1, sh;
      longint unsigned fx, fy, gx, gy, acc;
      logic [ris_pkg::PIX_W-1:0] p00, p01, p10, p11, res;
      if (it.opcode == ris_pkg::OP_WRITE) begin
        if (it.pos_x < 256 && it.pos_y < 256) begin
          pixels[it.pos_y * 256 + it.pos_x]  = {it.red_in, it.green_in, it.blue_in};
          written[it.pos_y * 256 + it.pos_x] = 1;
        end
        return;
      end
      neighbours(it.pos_x, it.pos_y, x0, x1, y0, y1, fx, fy);
      gx  = 256 - fx;
      gy  = 256 - fy;
      p00 = pixels[y0 * 256 + x0];
      p01 = pixels[y0 * 256 + x1];
      p10 = pixels[y1 * 256 + x0];
      p11 = pixels[y1 * 256 + x1];
      for (int k = 0; k < 3; k++) begin
        sh  = 16 - 8 * k;
        acc = gx * gy * ((p00 >> sh) & 255) + fx * gy * ((p01 >> sh) & 255)
            + gx * fy * ((p10 >> sh) & 255) + fx * fy * ((p11 >> sh) & 255);
        res[sh +: 8] = 8'(acc >> 16);
      end
      pending.push_back(ris_pkg::out_item_t'(res));
    endfunction

    function void check_result(ris_pkg::out_item_t got);
      ris_pkg::out_item_t exp_px;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      if (got.red_out != exp_px.red_out) begin
        $display("%0t: red expected %h got %h", $time, exp_px.red_out, got.red_out);
        errors++;
      end
      if (got.green_out != exp_px.green_out) begin
        $display("%0t: green expected %h got %h", $time, exp_px.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out != exp_px.blue_out) begin
        $display("%0t: blue expected %h got %h", $time, exp_px.blue_out, got.blue_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  ris_pkg::in_item_t  in_data;
  ris_pkg::out_item_t out_data;
  logic [ris_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ris_pkg::CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_left = 0;

  rgb_image_resample_sampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver: random stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // one input transaction, after idle cycles drawn one at a time
  task send(ris_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task write_px(int unsigned x, int unsigned y, logic [ris_pkg::PIX_W-1:0] rgb);
    ris_pkg::in_item_t it;
    it = '{ris_pkg::OP_WRITE, x[ris_pkg::POS_W-1:0], y[ris_pkg::POS_W-1:0],
           rgb[23:16], rgb[15:8], rgb[7:0]};
    send(it);
  endtask

  // sample, writing any neighbour that has never been stored first
  task sample(int unsigned px, int unsigned py);
    int unsigned x0, x1, y0, y1;
    longint unsigned fx, fy;
    ris_pkg::in_item_t it;
    sb.neighbours(px, py, x0, x1, y0, y1, fx, fy);
    if (!sb.written[y0 * 256 + x0]) write_px(x0, y0, ris_pkg::PIX_W'($urandom));
    if (!sb.written[y0 * 256 + x1]) write_px(x1, y0, ris_pkg::PIX_W'($urandom));
    if (!sb.written[y1 * 256 + x0]) write_px(x0, y1, ris_pkg::PIX_W'($urandom));
    if (!sb.written[y1 * 256 + x1]) write_px(x1, y1, ris_pkg::PIX_W'($urandom));
    it = '{ris_pkg::OP_SAMPLE, px[ris_pkg::POS_W-1:0], py[ris_pkg::POS_W-1:0],
           ris_pkg::CH_W'($urandom), ris_pkg::CH_W'($urandom), ris_pkg::CH_W'($urandom)};
    send(it);
  endtask

  // wait for the pipeline to drain, then load all four registers
  task configure(int unsigned sw, int unsigned sh, int unsigned on, int unsigned md);
    int unsigned vals [4];
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    vals = '{sw, sh, on, md};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ris_pkg::cfg_reg_t'(i);
      cfg_data  <= ris_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(ris_pkg::cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    #(4 * 3000000);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned cfgs [10][4];
    int unsigned lim;
    int unsigned n_txn;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, corner pixels, ignored writes, far samples
    write_px(0, 0, 24'h000000);
    write_px(255, 255, 24'hFFFFFF);
    write_px(639, 639, 24'hA5A5A5);
    write_px(256, 0, 24'h5A5A5A);
    write_px(0, 1023, 24'h123456);
    sample(0, 0);
    sample(255, 255);
    sample(1023, 1023);
    sample(639, 0);
    configure(256, 256, 256, ris_pkg::MODE_BILINEAR);
    write_px(1, 0, 24'hFF00FF);
    sample(0, 0);
    sample(255, 255);
    sample(1023, 512);
    configure(0, 0, 0, ris_pkg::MODE_BILINEAR);
    sample(0, 0);
    sample(1023, 1023);
    configure(511, 511, 1023, ris_pkg::MODE_NEAREST);
    sample(1023, 1023);
    sample(512, 341);

    // random phases over several register settings
    cfgs = '{'{256, 256, 640, 1}, '{1, 1, 1, 0}, '{7, 5, 640, 1}, '{200, 13, 3, 0},
             '{256, 256, 256, 1}, '{300, 400, 1023, 1}, '{16, 16, 100, 1},
             '{0, 256, 0, 0}, '{33, 90, 17, 1}, '{256, 1, 640, 0}};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 10) configure(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      else configure($urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 1023), $urandom_range(0, 1));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      // long hold-off while the sender keeps offering
      if (ph == 4) hold_req = 300;
      n_txn = (ph == 4) ? 30 : 10;
      lim = (sb.out_n == 0) ? 0 : sb.out_n - 1;
      for (int i = 0; i < n_txn; i++) begin
        if ($urandom_range(0, 99) < 20)
          write_px($urandom_range(0, 1023), $urandom_range(0, 1023),
                   ris_pkg::PIX_W'($urandom));
        else if ($urandom_range(0, 99) < 10)
          sample($urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          sample($urandom_range(0, lim), $urandom_range(0, lim));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
